[hdl/plid_pkg.sv]
// Package: shared types and constants for the positional list block.
`timescale 1ns / 1ps
package plid_pkg;

    localparam int POS_W  = 8;   // position field
    localparam int DATA_W = 32;  // element value
    localparam int LEN_W  = 5;   // list_length field

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_TRAV
    } t_state;

    // Command broadcast along the row of cells.
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_DELETE,
        CH_ROTATE
    } t_chain_cmd;

    typedef struct packed {
        t_chain_cmd               cmd;
        logic [POS_W-1:0]         pos_idx;   // 0-based target cell
        logic [POS_W-1:0]         tail_idx;  // 0-based last occupied cell
        logic signed [DATA_W-1:0] ins_value;
    } t_chain_ctrl;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] insert_value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] value;
        logic                     has_value;
        logic [LEN_W-1:0]         list_length;
        logic                     last;
    } t_out_item;

endpackage

[hdl/plid_in_if.sv]
// Interface: command item channel (valid/ready).
`timescale 1ns / 1ps
interface plid_in_if;
    import plid_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/plid_out_if.sv]
// Interface: result item channel (valid/ready).
`timescale 1ns / 1ps
interface plid_out_if;
    import plid_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/plid_cell.sv]
// One list cell: holds a single element and swaps data with its neighbours.
`timescale 1ns / 1ps
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  plid_pkg::t_chain_ctrl             i_ctrl,
    input  logic signed [plid_pkg::DATA_W-1:0] i_left,
    input  logic signed [plid_pkg::DATA_W-1:0] i_right,
    input  logic signed [plid_pkg::DATA_W-1:0] i_head,
    output logic signed [plid_pkg::DATA_W-1:0] o_data,
    output logic signed [plid_pkg::DATA_W-1:0] o_pick
);
    import plid_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.cmd)
            CH_INSERT: begin
                if (MY_IDX == i_ctrl.pos_idx) begin
                    n_data = i_ctrl.ins_value;
                end else if (MY_IDX > i_ctrl.pos_idx) begin
                    n_data = i_left;
                end
            end
            CH_DELETE: begin
                if (MY_IDX >= i_ctrl.pos_idx) begin
                    n_data = i_right;
                end
            end
            CH_ROTATE: begin
                // head wraps round to the tail, the rest move one place down
                if (MY_IDX == i_ctrl.tail_idx) begin
                    n_data = i_head;
                end else if (MY_IDX < i_ctrl.tail_idx) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_pick = (MY_IDX == i_ctrl.pos_idx) ? r_data : '0;

endmodule

[hdl/positional_list_insert_delete.sv]
// Top level: bounded positional list built as a row of shifting cells.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit elements, addressed by 1-based
// position. Each element lives in its own cell; cells form a row and hand data
// to their neighbours, so insert and delete move every later element together.
// An insert, a delete, a rejected command or a traverse of an empty list gives
// one result item. A traverse of a list of n elements first takes the command
// item and then gives one result item per element: the row rotates one place
// per result, element at the head cell goes out and wraps to the tail cell, so
// after n steps the list stands as it was. Result items sit in an output
// register; the block takes the next command item once the final result of
// the current one is in that register and the register is free or being
// emptied. A stalled output stalls the rotation. The element store has no
// reset; only occupied cells are ever read. The list_length field carries the
// low five bits of the element count.
module positional_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plid_in_if.sink     i_in,
    plid_out_if.source  o_out
);
    import plid_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left,  n_left;     // results still to go in a traverse
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic            w_slot_free;
    logic            w_in_fire;
    logic            w_in_ready;
    logic            w_out_load;
    t_chain_ctrl     w_ctrl;

    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_cnt_ext;
    logic [CMPW-1:0] w_len_ext;
    logic signed [DATA_W-1:0] w_removed;

    // ---------------------------------------------------------------------
    // Row of cells
    // ---------------------------------------------------------------------
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_pick [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_l;
            logic signed [DATA_W-1:0] w_r;
            if (g == 0) begin : g_first
                assign w_l = '0;
            end else begin : g_mid_l
                assign w_l = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_r = '0;
            end else begin : g_mid_r
                assign w_r = w_data[g+1];
            end
            plid_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_left  (w_l),
                .i_right (w_r),
                .i_head  (w_data[0]),
                .o_data  (w_data[g]),
                .o_pick  (w_pick[g])
            );
        end
    endgenerate

    // Removed element on a delete: only the addressed cell drives its pick.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_pick[k];
        end
    end

    // ---------------------------------------------------------------------
    // Handshake helpers
    // ---------------------------------------------------------------------
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_in_fire   = i_in.valid && w_in_ready;
    assign w_pos_ext   = CMPW'(i_in.data.position);
    assign w_cnt_ext   = CMPW'(r_count);
    assign w_len_ext   = CMPW'(n_count);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && i_in.data.opcode == OP_TRAVERSE && r_count != '0) begin
                    n_state = S_TRAV;
                end
            end
            S_TRAV: begin
                if (w_slot_free && r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Outputs of the sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        w_in_ready       = 1'b0;
        w_out_load       = 1'b0;
        w_ctrl.cmd       = CH_HOLD;
        w_ctrl.pos_idx   = i_in.data.position - POS_W'(1);
        w_ctrl.tail_idx  = POS_W'(r_count) - POS_W'(1);
        w_ctrl.ins_value = i_in.data.insert_value;
        n_count          = r_count;
        n_left           = r_left;
        n_out.status     = ST_OK;
        n_out.value      = '0;
        n_out.has_value  = 1'b0;
        n_out.list_length = '0;
        n_out.last       = 1'b1;

        case (r_state)
            S_IDLE: begin
                w_in_ready = w_slot_free;
                if (w_in_fire) begin
                    w_out_load = 1'b1;
                    case (i_in.data.opcode)
                        OP_INSERT: begin
                            if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext + CMPW'(1)) begin
                                n_out.status = ST_BAD_POS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ctrl.cmd = CH_INSERT;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext) begin
                                n_out.status = ST_BAD_POS;
                            end else begin
                                w_ctrl.cmd      = CH_DELETE;
                                n_count         = r_count - CW'(1);
                                n_out.value     = w_removed;
                                n_out.has_value = 1'b1;
                            end
                        end
                        OP_TRAVERSE: begin
                            // empty list answers at once; otherwise start rotating
                            if (r_count != '0) begin
                                w_out_load = 1'b0;
                                n_left     = r_count;
                            end
                        end
                        default: n_out.status = ST_BAD_POS;
                    endcase
                end
            end
            S_TRAV: begin
                if (w_slot_free) begin
                    w_out_load      = 1'b1;
                    w_ctrl.cmd      = CH_ROTATE;
                    n_out.value     = w_data[0];
                    n_out.has_value = 1'b1;
                    n_out.last      = (r_left == CW'(1));
                    n_left          = r_left - CW'(1);
                end
            end
            default: w_in_ready = 1'b0;
        endcase

        n_out.list_length = w_len_ext[LEN_W-1:0];
    end

    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_trav_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TRAV |-> !i_in.ready && r_left != '0)
        else $error("input taken or counter empty during traverse");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && i_in.data.opcode != OP_TRAVERSE |=> r_out_valid)
        else $error("no result after a single-result command item");

endmodule
